// File: src/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types and constants of the HTML entity decoder: the entity name
// table, its lengths and replacement characters, and the record types that
// pass between the matcher, the result register and the top level.
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int ENT_NUM   = 6;
    localparam int NAME_MAX  = 5;
    localparam int HOLD_MAX  = 4;
    localparam int BURST_MAX = 6;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    localparam logic [7:0] ENT_NAME [ENT_NUM][NAME_MAX] = '{
        '{8'h61, 8'h6D, 8'h70, CH_SEMI, 8'h00},
        '{8'h6C, 8'h74, CH_SEMI, 8'h00, 8'h00},
        '{8'h67, 8'h74, CH_SEMI, 8'h00, 8'h00},
        '{8'h71, 8'h75, 8'h6F, 8'h74, CH_SEMI},
        '{8'h61, 8'h70, 8'h6F, 8'h73, CH_SEMI},
        '{CH_HASH, CH_3, CH_9, CH_SEMI, 8'h00}
    };

    localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5, 3'd4};

    localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{
        CH_AMP, CH_LT, CH_GT, CH_QUOT, CH_APOS, CH_APOS
    };

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] data;
        logic [2:0]                cnt;
        logic                      fin;
    } burst_t;

    typedef struct packed {
        logic [2:0] count;
        logic       wr_en;
        logic [1:0] wr_idx;
    } hold_upd_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// File: src/html_entity_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_core
// Streaming decoder for &amp; &lt; &gt; &quot; &apos; and &#39;: holds a
// partial entity, replaces a completed one and releases a broken one.
//
//   channel | dir | tdata            | tlast     | tuser
//   s_*     | in  | [7:0] in_byte    | in_final  | -
//   m_*     | out | [7:0] out_byte   | text_end  | [0] run_end
//
// An input transaction is taken in the cycle it arrives when the result
// register is empty or hands over its last byte in that cycle.
// An input that yields k results occupies the output for k transactions, so the
// rate is one byte per cycle with m_tready high, except after a released hold (up to 6 results).
// A back-pressured output holds its byte and stalls input after the last one.
// Reset clears the hold count and empties the result register.
// ----------------------------------------------------------------------------
module html_entity_decoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic [0:0] m_tuser    // [0] run_end
);

    logic [2:0]         held_count_reg;
    logic [7:0]         held_chars_reg [hed_pkg::HOLD_MAX];
    hed_pkg::burst_t    burst;
    hed_pkg::hold_upd_t upd;
    logic               accept;

    assign accept = s_tvalid && s_tready;

    hed_match u_match (
        .in_byte    (s_tdata),
        .in_final   (s_tlast),
        .held_count (held_count_reg),
        .held_chars (held_chars_reg),
        .burst      (burst),
        .upd        (upd)
    );

    hed_burst u_burst (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .burst    (burst),
        .load_ok  (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= upd.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && upd.wr_en)
        begin
            held_chars_reg[upd.wr_idx] <= s_tdata;
        end
    end

endmodule

// File: src/hed_match.sv
// ----------------------------------------------------------------------------
// hed_match
// Entity matcher: compares the held bytes plus the new byte with every entity
// name and builds the list of result bytes and the update of the hold.
// ----------------------------------------------------------------------------
module hed_match (
    input  logic [7:0]          in_byte,
    input  logic                in_final,
    input  logic [2:0]          held_count,
    input  logic [7:0]          held_chars [hed_pkg::HOLD_MAX],
    output hed_pkg::burst_t     burst,
    output hed_pkg::hold_upd_t  upd
);

    logic [7:0] cand [hed_pkg::NAME_MAX];
    logic [7:0] rel  [hed_pkg::BURST_MAX];
    logic       done;
    logic       partial;
    logic [7:0] ent_ch;
    logic       in_range;
    logic       absorb;
    logic [2:0] rel_n;
    logic       tail_en;
    logic [7:0] tail;

    always_comb
    begin
        for (int p = 0; p < hed_pkg::HOLD_MAX; p++)
        begin
            cand[p] = (3'(p + 1) == held_count) ? in_byte : held_chars[p];
        end
        cand[hed_pkg::NAME_MAX-1] = in_byte;
    end

    always_comb
    begin
        logic ok;
        done    = 1'b0;
        partial = 1'b0;
        ent_ch  = hed_pkg::CH_AMP;
        for (int e = 0; e < hed_pkg::ENT_NUM; e++)
        begin
            ok = hed_pkg::ENT_LEN[e] >= held_count;
            for (int p = 0; p < hed_pkg::NAME_MAX; p++)
            begin
                if (3'(p) < held_count && hed_pkg::fold(cand[p]) != hed_pkg::ENT_NAME[e][p])
                begin
                    ok = 1'b0;
                end
            end
            if (ok && hed_pkg::ENT_LEN[e] == held_count && !done)
            begin
                done   = 1'b1;
                ent_ch = hed_pkg::ENT_CHAR[e];
            end
            else if (ok && hed_pkg::ENT_LEN[e] > held_count)
            begin
                partial = 1'b1;
            end
        end
    end

    assign in_range = (held_count != 3'd0) && (held_count <= 3'd5);
    assign absorb   = in_range && !done && partial && (held_count <= 3'd4);

    always_comb
    begin
        rel[0] = hed_pkg::CH_AMP;
        for (int k = 0; k < hed_pkg::HOLD_MAX; k++)
        begin
            rel[k+1] = held_chars[k];
        end
        rel[hed_pkg::BURST_MAX-1] = 8'h00;
    end

    always_comb
    begin
        upd.wr_en  = 1'b0;
        upd.wr_idx = 2'(held_count - 3'd1);
        if (in_range && done)
        begin
            rel_n     = 3'd0;
            tail_en   = 1'b1;
            tail      = ent_ch;
            upd.count = 3'd0;
        end
        else if (absorb)
        begin
            rel_n     = in_final ? held_count : 3'd0;
            tail_en   = in_final;
            tail      = in_byte;
            upd.count = in_final ? 3'd0 : held_count + 3'd1;
            upd.wr_en = 1'b1;
        end
        else
        begin
            rel_n = (held_count > 3'd5) ? 3'd5 : held_count;
            tail  = in_byte;
            if (in_byte == hed_pkg::CH_AMP)
            begin
                tail_en   = in_final;
                upd.count = in_final ? 3'd0 : 3'd1;
            end
            else
            begin
                tail_en   = 1'b1;
                upd.count = 3'd0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < hed_pkg::BURST_MAX; i++)
        begin
            if (3'(i) < rel_n)
            begin
                burst.data[i] = rel[i];
            end
            else if (3'(i) == rel_n)
            begin
                burst.data[i] = tail;
            end
            else
            begin
                burst.data[i] = 8'h00;
            end
        end
        burst.cnt = rel_n + {2'b00, tail_en};
        burst.fin = in_final;
    end

endmodule

// File: src/hed_burst.sv
// ----------------------------------------------------------------------------
// hed_burst
// Result register: holds the bytes produced by one input transaction and
// shifts them out one per output transaction, marking the last of the run.
// ----------------------------------------------------------------------------
module hed_burst (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  hed_pkg::burst_t burst,
    output logic            load_ok,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic [0:0]      m_tuser
);

    logic [7:0] data_reg [hed_pkg::BURST_MAX];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       fin_reg;
    logic       last;
    logic       take;

    assign last     = (cnt_reg == 3'd1);
    assign take     = m_tvalid && m_tready;
    assign load_ok  = (cnt_reg == 3'd0) || (last && m_tready);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = data_reg[0];
    assign m_tuser  = last;
    assign m_tlast  = last && fin_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = burst.cnt;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fin_reg <= burst.fin;
            for (int i = 0; i < hed_pkg::BURST_MAX; i++)
            begin
                data_reg[i] <= burst.data[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < hed_pkg::BURST_MAX - 1; i++)
            begin
                data_reg[i] <= data_reg[i+1];
            end
            data_reg[hed_pkg::BURST_MAX-1] <= 8'h00;
        end
    end

endmodule

// File: src/hed_checker.sv
// ----------------------------------------------------------------------------
// hed_checker
// Port-level checks of the HTML entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    a_text_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("text end without run end");

    a_ready_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && s_tready |-> m_tready && m_tuser[0])
        else $error("input taken while results still pending");

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("final input transaction produced no result");

endmodule

bind html_entity_decoder_core hed_checker u_hed_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for html_entity_decoder_core. A short table of directed
// bytes (extremes, each special case, entities completed mid-text and on the
// final byte) is followed by random text made mostly of whole or cut entity
// names in mixed case, plus noise. Each accepted byte runs through a local
// decoder model; its output bytes, or a literal row's table byte, are compared
// in order with the m_* stream. Idling on both sides moves through three phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int LIMIT = 200000;
    localparam int N_DIR = 24;
    localparam logic [7:0] C_AMP  = "&";
    localparam logic [7:0] C_SEMI = ";";
    localparam logic [7:0] C_HASH = "#";

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       text_end;
    } dec_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       lit;
        logic [7:0] exp_b;
        logic       exp_tend;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [0:0] m_tuser;

    string      ent_names [6] = '{"amp;", "lt;", "gt;", "quot;", "apos;", "#39;"};
    logic [7:0] ent_chars [6] = '{"&", "<", ">", 8'h22, 8'h27, 8'h27};
    string      mix = "&;#39amplgtquosAMPLGTQUOS";

    row_t dir_rows [N_DIR] = '{
        '{"A",    1'b0, 1'b1, "A",    1'b0},
        '{8'h00,  1'b0, 1'b1, 8'h00,  1'b0},
        '{8'hFF,  1'b1, 1'b1, 8'hFF,  1'b1},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{"a",    1'b0, 1'b0, 8'h00,  1'b0},
        '{"m",    1'b0, 1'b0, 8'h00,  1'b0},
        '{"p",    1'b0, 1'b0, 8'h00,  1'b0},
        '{C_SEMI, 1'b0, 1'b1, C_AMP,  1'b0},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{"L",    1'b0, 1'b0, 8'h00,  1'b0},
        '{"t",    1'b0, 1'b0, 8'h00,  1'b0},
        '{C_SEMI, 1'b1, 1'b1, "<",    1'b1},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{C_HASH, 1'b0, 1'b0, 8'h00,  1'b0},
        '{"3",    1'b0, 1'b0, 8'h00,  1'b0},
        '{"9",    1'b0, 1'b0, 8'h00,  1'b0},
        '{C_SEMI, 1'b0, 1'b1, 8'h27,  1'b0},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{"x",    1'b0, 1'b0, 8'h00,  1'b0},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{C_AMP,  1'b0, 1'b0, 8'h00,  1'b0},
        '{"g",    1'b1, 1'b0, 8'h00,  1'b0},
        '{C_AMP,  1'b1, 1'b1, C_AMP,  1'b1}
    };

    dec_t       expected_text [$];
    row_t       row_notes [$];
    logic [2:0] hold_len = 3'd0;
    logic [7:0] hold_buf [4];
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         items_sent = 0;
    int         bytes_checked = 0;
    int         finals_sent = 0;
    int         mismatches = 0;
    int         cycles = 0;

    html_entity_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic void release_hold(ref dec_t outs [$]);
        int cnt;
        if (hold_len != 3'd0)
        begin
            outs.insert(outs.size(), dec_t'{C_AMP, 1'b0, 1'b0});
            cnt = int'(hold_len) - 1;
            if (cnt > 4)
            begin
                cnt = 4;
            end
            for (int k = 0; k < cnt; k++)
            begin
                outs.insert(outs.size(), dec_t'{hold_buf[k], 1'b0, 1'b0});
            end
            hold_len = 3'd0;
        end
    endfunction

    function automatic void start_fresh(input logic [7:0] b, ref dec_t outs [$]);
        if (b == C_AMP)
        begin
            hold_len = 3'd1;
        end
        else
        begin
            outs.insert(outs.size(), dec_t'{b, 1'b0, 1'b0});
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin,
                                        ref dec_t outs [$]);
        int         n;
        bit         done;
        bit         partial;
        bit         ok;
        logic [7:0] cand;
        outs = {};
        done = 1'b0;
        partial = 1'b0;
        if (hold_len == 3'd0)
        begin
            start_fresh(b, outs);
        end
        else
        begin
            n = int'(hold_len);
            for (int e = 0; e < 6; e++)
            begin
                if (ent_names[e].len() < n)
                begin
                    continue;
                end
                ok = 1'b1;
                for (int p = 0; p < n; p++)
                begin
                    cand = (p == n - 1) ? b : hold_buf[p];
                    if (to_lower(cand) != ent_names[e][p])
                    begin
                        ok = 1'b0;
                    end
                end
                if (!ok)
                begin
                    continue;
                end
                if (ent_names[e].len() == n)
                begin
                    outs.insert(outs.size(), dec_t'{ent_chars[e], 1'b0, 1'b0});
                    hold_len = 3'd0;
                    done = 1'b1;
                    break;
                end
                partial = 1'b1;
            end
            if (!done)
            begin
                if (partial && n <= 4)
                begin
                    hold_buf[n - 1] = b;
                    hold_len = 3'(n + 1);
                end
                else
                begin
                    release_hold(outs);
                    start_fresh(b, outs);
                end
            end
        end
        if (fin)
        begin
            release_hold(outs);
        end
        if (outs.size() > 0)
        begin
            outs[outs.size() - 1].run_end = 1'b1;
            outs[outs.size() - 1].text_end = fin;
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input logic fin, input logic lit,
                             input logic [7:0] exp_b, input logic exp_tend);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        row_notes.insert(row_notes.size(), row_t'{b, fin, lit, exp_b, exp_tend});
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        items_sent++;
        if (fin)
        begin
            finals_sent++;
        end
    endtask

    task automatic send_plain(input logic [7:0] b);
        send_item(b, $urandom_range(0, 15) == 0, 1'b0, 8'h00, 1'b0);
    endtask

    task automatic send_text_burst();
        int         r;
        int         e;
        int         cut;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            e = $urandom_range(0, 5);
            cut = ent_names[e].len();
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(0, ent_names[e].len() - 1);
            end
            send_plain(C_AMP);
            for (int p = 0; p < cut; p++)
            begin
                c = ent_names[e][p];
                if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                begin
                    c = c - 8'h20;
                end
                send_plain(c);
            end
            if (cut < ent_names[e].len())
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    send_plain(mix[$urandom_range(0, mix.len() - 1)]);
                end
                else
                begin
                    send_plain(8'($urandom_range(0, 255)));
                end
            end
        end
        else if (r < 85)
        begin
            send_plain(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_plain(mix[$urandom_range(0, mix.len() - 1)]);
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        dec_t burst [$];
        dec_t want;
        row_t note;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: expected no output, got %02h run_end %0b text_end %0b",
                             $time, m_tdata, m_tuser[0], m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    bytes_checked++;
                    if (m_tdata !== want.data || m_tuser[0] !== want.run_end ||
                        m_tlast !== want.text_end)
                    begin
                        $display("%0t: expected byte %02h run_end %0b text_end %0b,",
                                 $time, want.data, want.run_end, want.text_end,
                                 " got byte %02h run_end %0b text_end %0b",
                                 m_tdata, m_tuser[0], m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                note = row_notes.pop_front();
                decode_byte(s_tdata, s_tlast, burst);
                if (note.lit)
                begin
                    expected_text.insert(expected_text.size(),
                                         dec_t'{note.exp_b, 1'b1, note.exp_tend});
                end
                else
                begin
                    foreach (burst[i])
                    begin
                        expected_text.insert(expected_text.size(), burst[i]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles, %0d outputs outstanding",
                     cycles, expected_text.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 27;
        rx_idle_pct = 52;
        for (int i = 0; i < N_DIR; i++)
        begin
            send_item(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].lit,
                      dir_rows[i].exp_b, dir_rows[i].exp_tend);
        end
        while (items_sent < 170)
        begin
            send_text_burst();
        end

        tx_idle_pct = 52;
        rx_idle_pct = 27;
        while (items_sent < 320)
        begin
            send_text_burst();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (items_sent < 450)
        begin
            send_text_burst();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        $display("sent %0d input bytes (%0d with tlast), checked %0d decoded bytes",
                 items_sent, finals_sent, bytes_checked);
        $display("idle phases: tx 27/rx 52, tx 52/rx 27, no idling");
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
src/hed_pkg.sv
src/hed_match.sv
src/hed_burst.sv
src/html_entity_decoder_core.sv
src/hed_checker.sv
verif/tb.sv
